/* hw/rtl/btl_pkg.sv */
`default_nettype none

package btl_pkg;

  localparam int unsigned NumReq     = 16;
  localparam int unsigned ReqBits    = 4;
  localparam int unsigned CntBits    = 5;
  localparam int unsigned TicketBits = 16;
  localparam int unsigned StatusBits = 2;

  localparam logic [TicketBits-1:0] TicketMax = {TicketBits{1'b1}};
  localparam logic [CntBits-1:0]    CntMax    = CntBits'(NumReq);

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 2'd0,
    ST_SATURATED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic               kind;
    logic [ReqBits-1:0] requester;
  } item_t;

  typedef struct packed {
    logic [TicketBits-1:0] ticket_value;
    logic [ReqBits-1:0]    holder;
    logic                  holder_valid;
    logic [StatusBits-1:0] status;
  } result_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic min_mode;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/btl_table.sv */
`default_nettype none

module btl_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           we_i,
  input  wire logic [btl_pkg::ReqBits-1:0]    waddr_i,
  input  wire logic [btl_pkg::TicketBits-1:0] wdata_i,
  input  wire logic [btl_pkg::ReqBits-1:0]    raddr_i,
  output logic      [btl_pkg::TicketBits-1:0] rdata_o
);
  import btl_pkg::*;

  logic [TicketBits-1:0] ticket_q [NumReq];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NumReq); i++) begin
        ticket_q[i] <= '0;
      end
    end else if (we_i) begin
      ticket_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = ticket_q[raddr_i];

endmodule

`default_nettype wire

/* hw/rtl/btl_scan.sv */
`default_nettype none

module btl_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire btl_pkg::scan_ctl_t             ctl_i,
  input  wire logic [btl_pkg::ReqBits-1:0]    idx_i,
  input  wire logic [btl_pkg::TicketBits-1:0] data_i,
  output logic      [btl_pkg::TicketBits-1:0] acc_o,
  output logic      [btl_pkg::ReqBits-1:0]    best_id_o,
  output logic                                found_o
);
  import btl_pkg::*;

  logic [TicketBits-1:0] acc_q, acc_d;
  logic [ReqBits-1:0]    best_id_q, best_id_d;
  logic                  found_q, found_d;
  logic                  lt;

  assign lt = data_i < acc_q;

  always_comb begin
    acc_d     = acc_q;
    best_id_d = best_id_q;
    found_d   = found_q;
    if (ctl_i.clr) begin
      acc_d     = '0;
      best_id_d = '0;
      found_d   = 1'b0;
    end else if (ctl_i.en) begin
      if (ctl_i.min_mode) begin
        if ((data_i != '0) && (!found_q || lt)) begin
          acc_d     = data_i;
          best_id_d = idx_i;
          found_d   = 1'b1;
        end
      end else if (!lt) begin
        acc_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      best_id_q <= '0;
      found_q   <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      best_id_q <= best_id_d;
      found_q   <= found_d;
    end
  end

  assign acc_o     = acc_q;
  assign best_id_o = best_id_q;
  assign found_o   = found_q;

endmodule

`default_nettype wire

/* hw/rtl/bakery_ticket_lock_arbiter.sv */
// A request scans the N active tickets for the max, writes max + 1 (saturating),
// then for the min; a release writes 0, then scans; an out-of-range id only scans.
// Throughput: one item at a time, the next accepted in the cycle done_o is high;
// the shared compare unit walks one ticket a cycle.
// Results are a single-cycle strobe on done_o; the receiver cannot stall.
// Reset clears all tickets at once and sets the active count to 16.
`default_nettype none

module bakery_ticket_lock_arbiter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire btl_pkg::item_t              req_i,
  output logic                             done_o,
  output btl_pkg::result_t                 res_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [btl_pkg::CntBits-1:0] cfg_data_i
);
  import btl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_WR,
    S_MIN
  } state_e;

  state_e                state_q, state_d;
  logic [CntBits-1:0]    cfg_q, cfg_d;
  logic [CntBits-1:0]    n_q, n_d;
  logic [CntBits-1:0]    idx_q, idx_d;
  logic                  kind_q, kind_d;
  logic [ReqBits-1:0]    req_q, req_d;
  status_e               status_q, status_d;
  logic [TicketBits-1:0] tval_q, tval_d;
  logic                  done_q, done_d;
  result_t               res_q, res_d;

  scan_ctl_t             scan_ctl;
  logic [TicketBits-1:0] rdata;
  logic [TicketBits-1:0] acc;
  logic [ReqBits-1:0]    best_id;
  logic                  found;
  logic                  we;
  logic [TicketBits-1:0] wdata;
  logic [CntBits-1:0]    n_in;
  logic                  scan_live;

  btl_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (req_q),
    .wdata_i (wdata),
    .raddr_i (idx_q[ReqBits-1:0]),
    .rdata_o (rdata)
  );

  btl_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .idx_i     (idx_q[ReqBits-1:0]),
    .data_i    (rdata),
    .acc_o     (acc),
    .best_id_o (best_id),
    .found_o   (found)
  );

  assign n_in      = (cfg_q > CntMax) ? CntMax : cfg_q;
  assign scan_live = idx_q < n_q;

  always_comb begin
    state_d  = state_q;
    cfg_d    = cfg_q;
    n_d      = n_q;
    idx_d    = idx_q;
    kind_d   = kind_q;
    req_d    = req_q;
    status_d = status_q;
    tval_d   = tval_q;
    done_d   = 1'b0;
    res_d    = res_q;
    scan_ctl = '0;
    we       = 1'b0;
    wdata    = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          scan_ctl.clr = 1'b1;
          n_d          = n_in;
          idx_d        = '0;
          kind_d       = req_i.kind;
          req_d        = req_i.requester;
          status_d     = ST_OK;
          tval_d       = '0;
          if ({1'b0, req_i.requester} >= n_in) begin
            status_d = ST_RANGE;
            state_d  = S_MIN;
          end else if (req_i.kind == KIND_RELEASE) begin
            state_d = S_WR;
          end else begin
            state_d = S_MAX;
          end
        end
      end
      S_MAX: begin
        if (scan_live) begin
          scan_ctl.en = 1'b1;
          idx_d       = idx_q + 1'b1;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        we           = 1'b1;
        scan_ctl.clr = 1'b1;
        idx_d        = '0;
        if (kind_q == KIND_RELEASE) begin
          wdata = '0;
        end else if (acc == TicketMax) begin
          wdata    = TicketMax;
          status_d = ST_SATURATED;
        end else begin
          wdata = acc + 1'b1;
        end
        tval_d  = wdata;
        state_d = S_MIN;
      end
      S_MIN: begin
        scan_ctl.min_mode = 1'b1;
        if (scan_live) begin
          scan_ctl.en = 1'b1;
          idx_d       = idx_q + 1'b1;
        end else begin
          res_d.ticket_value = tval_q;
          res_d.holder       = found ? best_id : '0;
          res_d.holder_valid = found;
          res_d.status       = status_q;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cfg_q    <= CntMax;
      n_q      <= '0;
      idx_q    <= '0;
      kind_q   <= 1'b0;
      req_q    <= '0;
      status_q <= ST_OK;
      tval_q   <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      cfg_q    <= cfg_d;
      n_q      <= n_d;
      idx_q    <= idx_d;
      kind_q   <= kind_d;
      req_q    <= req_d;
      status_q <= status_d;
      tval_q   <= tval_d;
      done_q   <= done_d;
      res_q    <= res_d;
    end
  end

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;
  assign done_o      = done_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* test/bakery_ticket_lock_arbiter_tb.sv */
`default_nettype none

module bakery_ticket_lock_arbiter_tb;
  import btl_pkg::*;

  localparam int unsigned      ClkHalf      = 10;
  localparam int unsigned      SettleCycles = 2 * NumReq + 8;
  localparam longint unsigned  CycleLimit   = 3_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               req_i;
  logic                done_o;
  result_t             res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CntBits-1:0]  cfg_data_i;

  logic [TicketBits-1:0] tickets [NumReq];
  logic [CntBits-1:0]    active_cnt;
  logic [ReqBits-1:0]    pred_holder;
  logic                  pred_holder_valid;
  result_t               owed_results [$];
  int unsigned           n_errors = 0;
  longint unsigned       cycle_cnt = 0;
  bit                    gaps_on;

  bakery_ticket_lock_arbiter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic result_t ticket_step(input item_t it);
    result_t               r;
    int unsigned           n;
    logic [TicketBits-1:0] top;
    logic [TicketBits-1:0] low;
    logic                  seen;
    r = '0;
    n = (active_cnt > CntMax) ? NumReq : active_cnt;
    if (it.requester >= n) begin
      r.status = ST_RANGE;
    end else if (it.kind == KIND_REQUEST) begin
      top = '0;
      for (int i = 0; i < n; i++) begin
        if (tickets[i] > top) top = tickets[i];
      end
      if (top == TicketMax) begin
        tickets[it.requester] = TicketMax;
        r.status = ST_SATURATED;
      end else begin
        tickets[it.requester] = top + 1'b1;
      end
      r.ticket_value = tickets[it.requester];
    end else begin
      tickets[it.requester] = '0;
    end
    seen = 1'b0;
    low  = '0;
    for (int i = 0; i < n; i++) begin
      if (tickets[i] != '0 && (!seen || tickets[i] < low)) begin
        seen     = 1'b1;
        low      = tickets[i];
        r.holder = ReqBits'(i);
      end
    end
    r.holder_valid    = seen;
    pred_holder       = r.holder;
    pred_holder_valid = seen;
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (owed_results.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        want = owed_results.pop_front();
        if (res_o.ticket_value !== want.ticket_value) begin
          $error("ticket_value: expected %0d, got %0d", want.ticket_value, res_o.ticket_value);
          n_errors++;
        end
        if (res_o.holder !== want.holder) begin
          $error("holder: expected %0d, got %0d", want.holder, res_o.holder);
          n_errors++;
        end
        if (res_o.holder_valid !== want.holder_valid) begin
          $error("holder_valid: expected %0d, got %0d", want.holder_valid, res_o.holder_valid);
          n_errors++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          n_errors++;
        end
      end
    end
  end

  task automatic issue(input kind_e k, input logic [ReqBits-1:0] id);
    item_t       it;
    int unsigned gap;
    it.kind      = k;
    it.requester = id;
    gap = (gaps_on && $urandom_range(99) < 28) ? $urandom_range(1, 40) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= it;
    do @(posedge clk_i); while (busy);
    owed_results.push_back(ticket_step(it));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_active(input logic [CntBits-1:0] n);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    active_cnt = n;
  endtask

  task automatic test_directed();
    issue(KIND_REQUEST, 4'd0);
    issue(KIND_REQUEST, 4'd15);
    issue(KIND_REQUEST, 4'd0);
    issue(KIND_RELEASE, 4'd15);
    issue(KIND_RELEASE, 4'd7);
    issue(KIND_REQUEST, 4'd9);
    set_active(5'd4);
    issue(KIND_REQUEST, 4'd9);
    issue(KIND_RELEASE, 4'd15);
    issue(KIND_REQUEST, 4'd3);
    issue(KIND_REQUEST, 4'd2);
    set_active(5'd0);
    issue(KIND_REQUEST, 4'd0);
    issue(KIND_RELEASE, 4'd0);
    set_active('1);
    issue(KIND_REQUEST, 4'd15);
    issue(KIND_REQUEST, 4'd9);
    set_active(5'd1);
    issue(KIND_RELEASE, 4'd0);
    issue(KIND_REQUEST, 4'd1);
    issue(KIND_REQUEST, 4'd0);
    set_active(CntMax);
    issue(KIND_RELEASE, 4'd2);
    issue(KIND_RELEASE, 4'd9);
  endtask

  task automatic random_item();
    int unsigned n;
    int unsigned pick;
    n    = (active_cnt > CntMax) ? NumReq : active_cnt;
    pick = $urandom_range(99);
    if (n == 0 || pick >= 85) begin
      issue(kind_e'($urandom_range(1)), ReqBits'($urandom_range(NumReq - 1)));
    end else if (pick < 45) begin
      issue(KIND_REQUEST, ReqBits'($urandom_range(n - 1)));
    end else if (pick < 75 && pred_holder_valid) begin
      issue(KIND_RELEASE, pred_holder);
    end else begin
      issue(KIND_RELEASE, ReqBits'($urandom_range(n - 1)));
    end
  endtask

  task automatic test_random();
    logic [CntBits-1:0] counts [8];
    counts = '{CntMax, 5'd1, 5'd2, 5'd31, 5'd0, 5'd17, 5'd8, CntMax};
    counts[6] = CntBits'($urandom_range(1, NumReq));
    foreach (counts[p]) begin
      set_active(counts[p]);
      gaps_on = (p != 6);
      repeat ((counts[p] == 0) ? 8 : 240) random_item();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    gaps_on           = 1'b1;
    active_cnt        = CntMax;
    pred_holder       = '0;
    pred_holder_valid = 1'b0;
    foreach (tickets[i]) tickets[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();

    start <= 1'b0;
    repeat (4 * SettleCycles) begin
      if (owed_results.size() != 0) @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (owed_results.size() != 0) begin
      $error("%0d expected results never arrived", owed_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* bakery_ticket_lock_arbiter.f */
hw/rtl/btl_pkg.sv
hw/rtl/btl_table.sv
hw/rtl/btl_scan.sv
hw/rtl/bakery_ticket_lock_arbiter.sv
test/bakery_ticket_lock_arbiter_tb.sv
